/* hw/rtl/stt_pkg.sv */
// Shared types, constants and byte-class helpers for the source text tokenizer.
// Used by stt_scanner, stt_queue, stt_emitter and source_text_tokenizer.
`timescale 1ns / 1ps

package stt_pkg;

    localparam int MAX_TEXT_BYTES = 65536;
    localparam logic [15:0] POS_LIMIT =
        (MAX_TEXT_BYTES > 65536) ? 16'hFFFF : 16'(MAX_TEXT_BYTES - 1);
    localparam logic [15:0] LINE_LIMIT = 16'hFFFF;

    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_NL    = 8'h0A;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_QUOTE = 8'h22;
    localparam logic [7:0] CH_SLASH = 8'h2F;
    localparam logic [7:0] CH_BSL   = 8'h5C;
    localparam logic [7:0] CH_NUL   = 8'h00;

    localparam logic [15:0] KW_FN     = 16'h666E;
    localparam logic [23:0] KW_LET    = 24'h6C6574;
    localparam logic [23:0] KW_INT    = 24'h696E74;
    localparam logic [47:0] KW_RETURN = 48'h72657475726E;

    typedef enum logic [2:0] {
        MODE_IDLE    = 3'd0,
        MODE_IDENT   = 3'd1,
        MODE_NUMBER  = 3'd2,
        MODE_STRING  = 3'd3,
        MODE_ESCAPE  = 3'd4,
        MODE_SLASH   = 3'd5,
        MODE_COMMENT = 3'd6
    } mode_t;

    typedef enum logic [4:0] {
        K_EOF     = 5'd0,
        K_ERROR   = 5'd1,
        K_IDENT   = 5'd2,
        K_INTEGER = 5'd3,
        K_STRING  = 5'd4,
        K_FN      = 5'd5,
        K_LET     = 5'd6,
        K_RETURN  = 5'd7,
        K_INT     = 5'd8,
        K_PLUS    = 5'd9,
        K_MINUS   = 5'd10,
        K_STAR    = 5'd11,
        K_SLASH   = 5'd12,
        K_ASSIGN  = 5'd13,
        K_SEMI    = 5'd14,
        K_LPAREN  = 5'd15,
        K_RPAREN  = 5'd16,
        K_LBRACE  = 5'd17,
        K_RBRACE  = 5'd18
    } kind_t;

    typedef struct packed {
        kind_t       kind;
        logic [15:0] start;
        logic [15:0] length;
        logic [15:0] line;
    } tok_t;

    // One queue entry: all tokens caused by one input beat, in order.
    typedef struct packed {
        tok_t tok0;
        tok_t tok1;
        logic two;
    } entry_t;

    function automatic logic is_letter(input logic [7:0] c);
        return (c inside {[8'h61:8'h7A], [8'h41:8'h5A]}) || (c == 8'h5F);
    endfunction

    function automatic logic is_digit(input logic [7:0] c);
        return c inside {[8'h30:8'h39]};
    endfunction

    function automatic kind_t op_kind(input logic [7:0] c);
        kind_t k;
        case (c)
            8'h2B:   k = K_PLUS;
            8'h2D:   k = K_MINUS;
            8'h2A:   k = K_STAR;
            8'h3D:   k = K_ASSIGN;
            8'h3B:   k = K_SEMI;
            8'h28:   k = K_LPAREN;
            8'h29:   k = K_RPAREN;
            8'h7B:   k = K_LBRACE;
            8'h7D:   k = K_RBRACE;
            default: k = K_ERROR;
        endcase
        return k;
    endfunction

    function automatic kind_t ident_kind(input logic [15:0] len, input logic [47:0] win);
        kind_t k;
        if (len == 16'd2 && win[15:0] == KW_FN) begin
            k = K_FN;
        end else if (len == 16'd3 && win[23:0] == KW_LET) begin
            k = K_LET;
        end else if (len == 16'd6 && win == KW_RETURN) begin
            k = K_RETURN;
        end else if (len == 16'd3 && win[23:0] == KW_INT) begin
            k = K_INT;
        end else begin
            k = K_IDENT;
        end
        return k;
    endfunction

endpackage

/* hw/rtl/stt_scanner.sv */
// Front end: scan state machine, one source byte per accepted beat.
// Builds the queue entry of up to two tokens per byte. Depends on stt_pkg.
`timescale 1ns / 1ps

module stt_scanner (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            accept_i,
    input  logic [7:0]      ch_i,
    input  logic            is_end_i,
    output logic            push_o,
    output stt_pkg::entry_t entry_o
);

    stt_pkg::mode_t mode_reg, mode_next;
    logic [15:0]    pos_reg, pos_next;
    logic [15:0]    line_reg, line_next;
    logic [15:0]    start_reg, start_next;
    logic [47:0]    win_reg, win_next;

    logic           line_inc;
    logic           end_w;
    logic [15:0]    len_w;
    logic [15:0]    pos_inc;

    // decode of a byte seen with no token pending
    stt_pkg::mode_t idle_mode;
    logic           idle_set_start;
    logic           idle_nl;
    logic           idle_emit;
    logic           is_word_ch;

    stt_pkg::tok_t  pend_tok, sec_tok;
    logic           pend_vld, sec_vld;

    assign end_w      = is_end_i || (ch_i == stt_pkg::CH_NUL);
    assign len_w      = pos_reg - start_reg;
    assign pos_inc    = (pos_reg < stt_pkg::POS_LIMIT) ? pos_reg + 16'd1 : pos_reg;
    assign is_word_ch = stt_pkg::is_letter(ch_i) || stt_pkg::is_digit(ch_i);

    always_comb begin
        idle_mode      = stt_pkg::MODE_IDLE;
        idle_set_start = 1'b1;
        idle_nl        = 1'b0;
        idle_emit      = 1'b0;
        if (ch_i == stt_pkg::CH_SPACE || ch_i == stt_pkg::CH_TAB || ch_i == stt_pkg::CH_CR) begin
            idle_set_start = 1'b0;
        end else if (ch_i == stt_pkg::CH_NL) begin
            idle_set_start = 1'b0;
            idle_nl        = 1'b1;
        end else if (stt_pkg::is_letter(ch_i)) begin
            idle_mode = stt_pkg::MODE_IDENT;
        end else if (stt_pkg::is_digit(ch_i)) begin
            idle_mode = stt_pkg::MODE_NUMBER;
        end else if (ch_i == stt_pkg::CH_QUOTE) begin
            idle_mode = stt_pkg::MODE_STRING;
        end else if (ch_i == stt_pkg::CH_SLASH) begin
            idle_mode = stt_pkg::MODE_SLASH;
        end else begin
            idle_emit = 1'b1;
        end
    end

    // next state
    always_comb begin
        logic take_idle;
        take_idle  = 1'b0;
        mode_next  = mode_reg;
        start_next = start_reg;
        win_next   = win_reg;
        line_inc   = 1'b0;
        case (mode_reg)
            stt_pkg::MODE_IDENT: begin
                if (is_word_ch) begin
                    win_next = {win_reg[39:0], ch_i};
                end else begin
                    take_idle = 1'b1;
                end
            end
            stt_pkg::MODE_NUMBER: begin
                take_idle = !stt_pkg::is_digit(ch_i);
            end
            stt_pkg::MODE_STRING: begin
                if (ch_i == stt_pkg::CH_QUOTE) begin
                    mode_next = stt_pkg::MODE_IDLE;
                end else if (ch_i == stt_pkg::CH_BSL) begin
                    mode_next = stt_pkg::MODE_ESCAPE;
                end else if (ch_i == stt_pkg::CH_NL) begin
                    line_inc = 1'b1;
                end
            end
            stt_pkg::MODE_ESCAPE: begin
                mode_next = stt_pkg::MODE_STRING;
            end
            stt_pkg::MODE_SLASH: begin
                if (ch_i == stt_pkg::CH_SLASH) begin
                    mode_next = stt_pkg::MODE_COMMENT;
                end else begin
                    take_idle = 1'b1;
                end
            end
            stt_pkg::MODE_COMMENT: begin
                if (ch_i == stt_pkg::CH_NL) begin
                    line_inc  = 1'b1;
                    mode_next = stt_pkg::MODE_IDLE;
                end
            end
            default: begin
                take_idle = 1'b1;
            end
        endcase
        if (take_idle) begin
            mode_next = idle_mode;
            line_inc  = idle_nl;
            if (idle_set_start) begin
                start_next = pos_reg;
            end
            if (idle_mode == stt_pkg::MODE_IDENT) begin
                win_next = {40'd0, ch_i};
            end
        end
        line_next = (line_inc && line_reg != stt_pkg::LINE_LIMIT) ? line_reg + 16'd1 : line_reg;
        pos_next  = pos_inc;
        // end of text: restart from reset values
        if (end_w) begin
            mode_next  = stt_pkg::MODE_IDLE;
            start_next = 16'd0;
            win_next   = 48'd0;
            line_next  = 16'd1;
            pos_next   = 16'd0;
        end
    end

    // token outputs
    always_comb begin
        logic flush;
        flush    = 1'b0;
        pend_vld = 1'b0;
        pend_tok = '{kind: stt_pkg::K_IDENT, start: start_reg, length: len_w, line: line_reg};
        sec_vld  = 1'b0;
        sec_tok  = '{kind: stt_pkg::op_kind(ch_i), start: pos_reg, length: 16'd1,
                     line: line_reg};
        if (end_w) begin
            sec_vld = 1'b1;
            sec_tok = '{kind: stt_pkg::K_EOF, start: pos_reg, length: 16'd0, line: line_reg};
            if (mode_reg == stt_pkg::MODE_STRING || mode_reg == stt_pkg::MODE_ESCAPE) begin
                pend_vld      = 1'b1;
                pend_tok.kind = stt_pkg::K_ERROR;
            end else begin
                flush = 1'b1;
            end
        end else begin
            case (mode_reg)
                stt_pkg::MODE_IDENT: begin
                    flush = !is_word_ch;
                end
                stt_pkg::MODE_NUMBER: begin
                    flush = !stt_pkg::is_digit(ch_i);
                end
                stt_pkg::MODE_SLASH: begin
                    flush = (ch_i != stt_pkg::CH_SLASH);
                end
                stt_pkg::MODE_STRING: begin
                    if (ch_i == stt_pkg::CH_QUOTE) begin
                        pend_vld        = 1'b1;
                        pend_tok.kind   = stt_pkg::K_STRING;
                        pend_tok.length = pos_inc - start_reg;
                    end
                end
                stt_pkg::MODE_ESCAPE, stt_pkg::MODE_COMMENT: begin
                    pend_vld = 1'b0;
                end
                default: begin
                    sec_vld = idle_emit;
                end
            endcase
            if (flush) begin
                sec_vld = idle_emit;
            end
        end
        if (flush) begin
            case (mode_reg)
                stt_pkg::MODE_IDENT: begin
                    pend_vld      = 1'b1;
                    pend_tok.kind = stt_pkg::ident_kind(len_w, win_reg);
                end
                stt_pkg::MODE_NUMBER: begin
                    pend_vld      = 1'b1;
                    pend_tok.kind = stt_pkg::K_INTEGER;
                end
                stt_pkg::MODE_SLASH: begin
                    pend_vld        = 1'b1;
                    pend_tok.kind   = stt_pkg::K_SLASH;
                    pend_tok.length = 16'd1;
                end
                default: begin
                    pend_vld = 1'b0;
                end
            endcase
        end
    end

    assign push_o       = accept_i && (pend_vld || sec_vld);
    assign entry_o.tok0 = pend_vld ? pend_tok : sec_tok;
    assign entry_o.tok1 = sec_tok;
    assign entry_o.two  = pend_vld && sec_vld;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg  <= stt_pkg::MODE_IDLE;
            pos_reg   <= 16'd0;
            line_reg  <= 16'd1;
            start_reg <= 16'd0;
            win_reg   <= 48'd0;
        end else if (accept_i) begin
            mode_reg  <= mode_next;
            pos_reg   <= pos_next;
            line_reg  <= line_next;
            start_reg <= start_next;
            win_reg   <= win_next;
        end
    end

endmodule

/* hw/rtl/stt_queue.sv */
// Short register queue of token entries between scanner and emitter.
// Depends on stt_pkg.
`timescale 1ns / 1ps

module stt_queue (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            push_i,
    input  stt_pkg::entry_t push_data_i,
    input  logic            pop_i,
    output stt_pkg::entry_t head_o,
    output logic            full_o,
    output logic            empty_o
);

    stt_pkg::entry_t                 store_reg [stt_pkg::QUEUE_DEPTH];
    logic [stt_pkg::QUEUE_AW-1:0]    wr_ptr_reg, rd_ptr_reg;
    logic [stt_pkg::QUEUE_AW:0]      count_reg, count_next;

    assign full_o  = (count_reg == (stt_pkg::QUEUE_AW+1)'(stt_pkg::QUEUE_DEPTH));
    assign empty_o = (count_reg == '0);
    assign head_o  = store_reg[rd_ptr_reg];

    always_comb begin
        count_next = count_reg;
        if (push_i && !pop_i) begin
            count_next = count_reg + 1'b1;
        end else if (pop_i && !push_i) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            count_reg <= count_next;
            if (push_i) begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop_i) begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (push_i) begin
            store_reg[wr_ptr_reg] <= push_data_i;
        end
    end

`ifndef SYNTH
    a_no_overflow: assert property (@(posedge aclk) disable iff (!aresetn)
        push_i |-> !full_o)
        else $error("queue push while full");
    a_no_underflow: assert property (@(posedge aclk) disable iff (!aresetn)
        pop_i |-> !empty_o)
        else $error("queue pop while empty");
    a_count_track: assert property (@(posedge aclk) disable iff (!aresetn)
        (push_i && !pop_i) |=> (count_reg == $past(count_reg) + 1'b1))
        else $error("queue count lost a push");
`endif

endmodule

/* hw/rtl/stt_emitter.sv */
// Back end: turns the head queue entry into one or two output beats.
// Depends on stt_pkg.
`timescale 1ns / 1ps

module stt_emitter (
    input  logic            aclk,
    input  logic            aresetn,
    input  stt_pkg::entry_t head_i,
    input  logic            empty_i,
    output logic            pop_o,
    output logic            m_tvalid,
    input  logic            m_tready,
    output stt_pkg::tok_t   tok_o,
    output logic            m_tlast
);

    logic sel_reg, sel_next;
    logic beat;

    assign m_tvalid = !empty_i;
    assign tok_o    = sel_reg ? head_i.tok1 : head_i.tok0;
    assign m_tlast  = !head_i.two || sel_reg;
    assign beat     = m_tvalid && m_tready;
    assign pop_o    = beat && m_tlast;

    always_comb begin
        sel_next = sel_reg;
        if (beat) begin
            sel_next = !m_tlast;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sel_reg <= 1'b0;
        end else begin
            sel_reg <= sel_next;
        end
    end

endmodule

/* hw/rtl/source_text_tokenizer.sv */
// Source text tokenizer: one ASCII byte per s_ beat in, tokens out on m_.
// A token enters the queue with the byte that completes it, then is offered on m_.
// Throughput: one byte per cycle unless the queue is full; a byte closing two tokens
// takes two m_ beats; the four-entry queue sets how far scanner and emitter slip.
// Reset: aresetn low at a clock edge restarts scanning at offset 0, line 1,
// and empties the queue. End of text does the same restart after its eof token.
`timescale 1ns / 1ps

module source_text_tokenizer (
    input  logic        aclk,
    input  logic        aresetn,
    // input bytes
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] ch
    input  logic        s_tuser,   // [0] is_end
    // tokens
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [55:0] m_tdata,   // [4:0] kind, [20:5] start_offset,
                                   // [36:21] token_length, [52:37] line_number, rest 0
    output logic        m_tlast    // last_of_run
);

    logic            accept;
    logic            push;
    logic            pop;
    logic            full;
    logic            empty;
    stt_pkg::entry_t entry;
    stt_pkg::entry_t head;
    stt_pkg::tok_t   tok;

    // take a byte whenever the queue has room; bytes that make no token
    // still need that room only as a simple guard
    assign s_tready = !full;
    assign accept   = s_tvalid && s_tready;

    stt_scanner u_scanner (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .accept_i (accept),
        .ch_i     (s_tdata),
        .is_end_i (s_tuser),
        .push_o   (push),
        .entry_o  (entry)
    );

    stt_queue u_queue (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .push_i      (push),
        .push_data_i (entry),
        .pop_i       (pop),
        .head_o      (head),
        .full_o      (full),
        .empty_o     (empty)
    );

    stt_emitter u_emitter (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .head_i   (head),
        .empty_i  (empty),
        .pop_o    (pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .tok_o    (tok),
        .m_tlast  (m_tlast)
    );

    // pack fields lowest first, pad to whole bytes
    assign m_tdata = {3'b000, tok.line, tok.length, tok.start, tok.kind};

endmodule

/* tb/sv/source_text_tokenizer_test.sv */
// Self-checking testbench for source_text_tokenizer: random and directed source text in,
// every token compared with an in-bench lexer model. Depends on stt_pkg and the RTL top only.
`timescale 1ns / 1ps

module source_text_tokenizer_test;
    import stt_pkg::*;

    localparam int QUIET_LIMIT    = 2000;  // cycles with no beat on either side
    localparam int DRAIN_CYCLES   = 20;
    localparam int RANDOM_HALF    = 335;
    localparam int REPORT_LIMIT   = 30;

    // one text byte or end marker waiting to go out on s_
    typedef struct {
        logic [7:0] ch;
        logic       is_end;
        bit         quick;   // no gap after this beat
    } text_beat_t;

    typedef struct {
        kind_t       kind;
        logic [15:0] start;
        logic [15:0] length;
        logic [15:0] line;
        logic        last;
    } token_t;

    logic        aclk     = 1'b0;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata  = 8'h00;
    logic        s_tuser  = 1'b0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [55:0] m_tdata;
    logic        m_tlast;

    source_text_tokenizer dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    text_beat_t text_beats[$];   // stimulus not yet driven
    token_t     tokens_due[$];   // predicted tokens not yet seen on m_
    token_t     run_toks[$];     // tokens caused by the beat being predicted

    int errors         = 0;
    int tokens_checked = 0;
    int beats_taken    = 0;
    int texts_done     = 0;
    int quiet_cycles   = 0;

    // lexer model state
    mode_t       scan_mode_q = MODE_IDLE;
    logic [15:0] pos_q       = 16'd0;
    logic [15:0] line_q      = 16'd1;
    logic [15:0] tstart_q    = 16'd0;
    logic [47:0] win_q       = 48'd0;

    // ------------------------------------------------------------------
    // Lexer model
    // ------------------------------------------------------------------
    function automatic logic letter_byte(input logic [7:0] c);
        return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") || c == "_";
    endfunction

    function automatic logic digit_byte(input logic [7:0] c);
        return c >= "0" && c <= "9";
    endfunction

    function automatic logic [15:0] step_pos(input logic [15:0] p);
        return (p < POS_LIMIT) ? p + 16'd1 : p;
    endfunction

    function automatic kind_t op_token(input logic [7:0] c);
        case (c)
            "+":     return K_PLUS;
            "-":     return K_MINUS;
            "*":     return K_STAR;
            "=":     return K_ASSIGN;
            ";":     return K_SEMI;
            "(":     return K_LPAREN;
            ")":     return K_RPAREN;
            "{":     return K_LBRACE;
            "}":     return K_RBRACE;
            default: return K_ERROR;
        endcase
    endfunction

    // keywords are matched on the last bytes seen plus the exact length
    function automatic kind_t word_token(input logic [15:0] len, input logic [47:0] w);
        if (len == 16'd2 && w[15:0] == KW_FN) return K_FN;
        if (len == 16'd3 && w[23:0] == KW_LET) return K_LET;
        if (len == 16'd6 && w == KW_RETURN) return K_RETURN;
        if (len == 16'd3 && w[23:0] == KW_INT) return K_INT;
        return K_IDENT;
    endfunction

    task automatic add_token(input kind_t k, input logic [15:0] s, input logic [15:0] l);
        token_t t;
        t.kind   = k;
        t.start  = s;
        t.length = l;
        t.line   = line_q;
        t.last   = 1'b0;
        run_toks.push_back(t);
    endtask

    task automatic bump_line();
        if (line_q < LINE_LIMIT) line_q = line_q + 16'd1;
    endtask

    // byte seen with no token open
    task automatic start_from_idle(input logic [7:0] c);
        if (c == CH_NL) begin
            bump_line();
        end else if (c != CH_SPACE && c != CH_TAB && c != CH_CR) begin
            tstart_q = pos_q;
            if (letter_byte(c)) begin
                scan_mode_q = MODE_IDENT;
                win_q = {40'd0, c};
            end else if (digit_byte(c)) begin
                scan_mode_q = MODE_NUMBER;
            end else if (c == CH_QUOTE) begin
                scan_mode_q = MODE_STRING;
            end else if (c == CH_SLASH) begin
                scan_mode_q = MODE_SLASH;
            end else begin
                add_token(op_token(c), pos_q, 16'd1);
            end
        end
    endtask

    // close an open word, number or lone slash
    task automatic close_pending();
        logic [15:0] len;
        len = pos_q - tstart_q;
        case (scan_mode_q)
            MODE_IDENT:  add_token(word_token(len, win_q), tstart_q, len);
            MODE_NUMBER: add_token(K_INTEGER, tstart_q, len);
            MODE_SLASH:  add_token(K_SLASH, tstart_q, 16'd1);
            default: ;
        endcase
        scan_mode_q = MODE_IDLE;
    endtask

    task automatic predict_beat(input logic [7:0] c, input logic end_in);
        token_t t;
        run_toks.delete();
        if (end_in || c == CH_NUL) begin
            if (scan_mode_q == MODE_STRING || scan_mode_q == MODE_ESCAPE) begin
                add_token(K_ERROR, tstart_q, pos_q - tstart_q);
            end else begin
                close_pending();
            end
            add_token(K_EOF, pos_q, 16'd0);
            scan_mode_q = MODE_IDLE;
            pos_q       = 16'd0;
            line_q      = 16'd1;
            tstart_q    = 16'd0;
            win_q       = 48'd0;
            texts_done++;
        end else begin
            case (scan_mode_q)
                MODE_IDENT: begin
                    if (letter_byte(c) || digit_byte(c)) begin
                        win_q = {win_q[39:0], c};
                    end else begin
                        close_pending();
                        start_from_idle(c);
                    end
                end
                MODE_NUMBER: begin
                    if (!digit_byte(c)) begin
                        close_pending();
                        start_from_idle(c);
                    end
                end
                MODE_STRING: begin
                    if (c == CH_QUOTE) begin
                        add_token(K_STRING, tstart_q, step_pos(pos_q) - tstart_q);
                        scan_mode_q = MODE_IDLE;
                    end else if (c == CH_BSL) begin
                        scan_mode_q = MODE_ESCAPE;
                    end else if (c == CH_NL) begin
                        bump_line();
                    end
                end
                // escaped byte is swallowed unseen, newline included
                MODE_ESCAPE: scan_mode_q = MODE_STRING;
                MODE_SLASH: begin
                    if (c == CH_SLASH) begin
                        scan_mode_q = MODE_COMMENT;
                    end else begin
                        close_pending();
                        start_from_idle(c);
                    end
                end
                MODE_COMMENT: begin
                    if (c == CH_NL) begin
                        bump_line();
                        scan_mode_q = MODE_IDLE;
                    end
                end
                default: begin
                    scan_mode_q = MODE_IDLE;
                    start_from_idle(c);
                end
            endcase
            pos_q = step_pos(pos_q);
        end
        foreach (run_toks[i]) begin
            t = run_toks[i];
            t.last = (i == run_toks.size() - 1);
            tokens_due.push_back(t);
        end
    endtask

    // ------------------------------------------------------------------
    // Stimulus builders
    // ------------------------------------------------------------------
    task automatic push_byte(input logic [7:0] c, input bit quick);
        text_beat_t b;
        b.ch     = c;
        b.is_end = 1'b0;
        b.quick  = quick;
        text_beats.push_back(b);
    endtask

    task automatic push_str(input string s);
        for (int i = 0; i < s.len(); i++) push_byte(s[i], 1'b0);
    endtask

    // end marker: the data byte is a don't-care, so randomize it
    task automatic push_end();
        text_beat_t b;
        b.ch     = 8'($urandom_range(0, 255));
        b.is_end = 1'b1;
        b.quick  = 1'b0;
        text_beats.push_back(b);
    endtask

    // mostly well-formed program text with random content, some noise
    task automatic gen_text();
        string word_chars;
        string op_chars;
        string keywords[4];
        int    sel;
        int    n;
        logic [7:0] c;
        word_chars  = "abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ_0123456789";
        op_chars    = "+-*/=;(){}";
        keywords[0] = "fn";
        keywords[1] = "let";
        keywords[2] = "return";
        keywords[3] = "int";
        repeat ($urandom_range(1, 12)) begin
            sel = $urandom_range(0, 99);
            if (sel < 14) begin
                push_str(keywords[$urandom_range(0, 3)]);
            end else if (sel < 32) begin
                push_byte(word_chars[$urandom_range(0, 52)], 1'b0);
                repeat ($urandom_range(0, 7)) push_byte(word_chars[$urandom_range(0, 62)], 1'b0);
            end else if (sel < 42) begin
                repeat ($urandom_range(1, 6)) push_byte(8'("0" + $urandom_range(0, 9)), 1'b0);
            end else if (sel < 56) begin
                push_byte(op_chars[$urandom_range(0, 9)], 1'b0);
            end else if (sel < 66) begin
                // string body: plain bytes, newlines and escapes of any nonzero byte
                push_byte(CH_QUOTE, 1'b0);
                repeat ($urandom_range(0, 6)) begin
                    n = $urandom_range(0, 9);
                    if (n == 0) begin
                        push_byte(CH_BSL, 1'b0);
                        push_byte(8'($urandom_range(1, 255)), 1'b0);
                    end else if (n == 1) begin
                        push_byte(CH_NL, 1'b0);
                    end else begin
                        c = 8'($urandom_range(1, 255));
                        if (c == CH_QUOTE || c == CH_BSL) c = "s";
                        push_byte(c, 1'b0);
                    end
                end
                push_byte(CH_QUOTE, 1'b0);
            end else if (sel < 72) begin
                push_str("//");
                repeat ($urandom_range(0, 8)) begin
                    c = 8'($urandom_range(1, 255));
                    push_byte((c == CH_NL) ? 8'h41 : c, 1'b0);
                end
                push_byte(CH_NL, 1'b0);
            end else if (sel < 76) begin
                push_byte(CH_SLASH, 1'b0);
            end else if (sel < 82) begin
                push_byte(8'($urandom_range(1, 255)), 1'b0);
            end
            // separator, often none so tokens abut
            case ($urandom_range(0, 9))
                0, 1, 2, 3: ;
                4, 5:       push_byte(CH_SPACE, 1'b0);
                6:          push_byte(CH_TAB, 1'b0);
                7:          push_byte(CH_CR, 1'b0);
                default:    push_byte(CH_NL, 1'b0);
            endcase
        end
        sel = $urandom_range(0, 19);
        if (sel == 0) begin
            // broken text: string left open at the end
            push_byte(CH_QUOTE, 1'b0);
            repeat ($urandom_range(0, 3)) push_byte(word_chars[$urandom_range(0, 62)], 1'b0);
            if ($urandom_range(0, 1)) push_byte(CH_BSL, 1'b0);
            push_end();
        end else if (sel < 3) begin
            push_byte(CH_NUL, 1'b0);
        end else begin
            push_end();
        end
    endtask

    task automatic add_random_texts(input int count);
        int target;
        target = text_beats.size() + count;
        while (text_beats.size() < target) gen_text();
    endtask

    // ------------------------------------------------------------------
    // Source driver: draw a gap for every beat, hold data until taken
    // ------------------------------------------------------------------
    bit in_taken   = 1'b0;
    bit out_taken  = 1'b0;
    bit cur_quick  = 1'b0;
    int gap_left   = 0;
    int hold_left  = 0;
    int calm_in    = 0;
    int calm_out   = 0;

    // random wait between beats, with occasional runs of back-to-back beats
    function automatic int draw_wait(inout int calm);
        if (calm > 0) begin
            calm--;
            return 0;
        end
        if ($urandom_range(0, 15) == 0) begin
            calm = $urandom_range(8, 40);
            return 0;
        end
        return $urandom_range(0, 10);
    endfunction

    always @(negedge aclk) begin
        text_beat_t b;
        if (aresetn && (!s_tvalid || in_taken)) begin
            if (s_tvalid) begin
                gap_left = cur_quick ? 0 : draw_wait(calm_in);
            end else if (gap_left > 0) begin
                gap_left--;
            end
            if (gap_left == 0 && text_beats.size() > 0) begin
                b = text_beats.pop_front();
                cur_quick = b.quick;
                s_tdata  <= b.ch;
                s_tuser  <= b.is_end;
                s_tvalid <= 1'b1;
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------
    // Token sink: stall for a drawn number of cycles after every beat
    // ------------------------------------------------------------------
    always @(negedge aclk) begin
        if (aresetn && (!m_tready || out_taken)) begin
            if (m_tready) begin
                hold_left = draw_wait(calm_out);
            end else if (hold_left > 0) begin
                hold_left--;
            end
            m_tready <= (hold_left == 0);
        end
    end

    task automatic note_mismatch(input string what, input logic [15:0] want,
                                 input logic [15:0] got);
        errors++;
        if (errors <= REPORT_LIMIT) begin
            $display("%0t: token %0d %s expected %0d, got %0d",
                     $time, tokens_checked, what, want, got);
        end
    endtask

    // ------------------------------------------------------------------
    // Scoreboard: predict on every byte beat, check every token beat
    // ------------------------------------------------------------------
    always @(posedge aclk) begin
        token_t want;
        in_taken  <= s_tvalid && s_tready;
        out_taken <= m_tvalid && m_tready;
        if (aresetn) begin
            // predict first so a same-edge token would still find its entry
            if (s_tvalid && s_tready) begin
                beats_taken++;
                predict_beat(s_tdata, s_tuser);
            end
            if (m_tvalid && m_tready) begin
                tokens_checked++;
                if (tokens_due.size() == 0) begin
                    errors++;
                    if (errors <= REPORT_LIMIT) begin
                        $display("%0t: token %0d expected none, got kind %0d start %0d",
                                 $time, tokens_checked, m_tdata[4:0], m_tdata[20:5]);
                    end
                end else begin
                    want = tokens_due.pop_front();
                    if (m_tdata[4:0] !== want.kind)
                        note_mismatch("kind", 16'(want.kind), 16'(m_tdata[4:0]));
                    if (m_tdata[20:5] !== want.start)
                        note_mismatch("start_offset", want.start, m_tdata[20:5]);
                    if (m_tdata[36:21] !== want.length)
                        note_mismatch("token_length", want.length, m_tdata[36:21]);
                    if (m_tdata[52:37] !== want.line)
                        note_mismatch("line_number", want.line, m_tdata[52:37]);
                    if (m_tlast !== want.last)
                        note_mismatch("last_of_run", 16'(want.last), 16'(m_tlast));
                end
            end
            // watchdog: a stuck handshake on either side ends the run
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
                quiet_cycles = 0;
            end else begin
                quiet_cycles++;
            end
            if (quiet_cycles >= QUIET_LIMIT) begin
                $display("%0t: no beat for %0d cycles, %0d tokens outstanding",
                         $time, quiet_cycles, tokens_due.size());
                $display("SCOREBOARD MISMATCH");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------
    // Sequence: build all stimulus, release reset, drain, report
    // ------------------------------------------------------------------
    initial begin
        // keyword and lone slash before a digit, number closed by a slash,
        // comment, escaped newline inside a string, byte 255, byte 0 as end
        push_str("fn/2//\n\"\\\n\"");
        push_byte(8'hFF, 1'b0);
        push_byte(CH_NUL, 1'b0);
        // delimiter giving two tokens in one beat, string open at end of text
        push_str("a+\"x");
        push_end();
        // byte 128 unknown, number flushed by the end marker
        push_byte(8'h80, 1'b0);
        push_str("7");
        push_end();
        // slash flushed by the end marker, then an empty text
        push_str("/");
        push_end();
        push_end();

        add_random_texts(RANDOM_HALF);

        // escaped quote inside a string, then a slash closed by the end marker
        push_str("xyz \"q\\\"\" 12 ");
        push_byte(CH_NL, 1'b0);
        push_str("/");
        push_end();

        add_random_texts(RANDOM_HALF);

        repeat (2) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        while (text_beats.size() > 0 || s_tvalid) @(posedge aclk);
        while (tokens_due.size() > 0) @(posedge aclk);
        // let any stray extra token show up
        repeat (DRAIN_CYCLES) @(posedge aclk);

        $display("Covered %0d texts in %0d byte beats and checked %0d tokens,",
                 texts_done, beats_taken, tokens_checked);
        $display("including keywords, escapes, comments and open strings; %0d mismatches.",
                 errors);
        if (errors == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule

/* source_text_tokenizer.f */
hw/rtl/stt_pkg.sv
hw/rtl/stt_scanner.sv
hw/rtl/stt_queue.sv
hw/rtl/stt_emitter.sv
hw/rtl/source_text_tokenizer.sv
tb/sv/source_text_tokenizer_test.sv
